// ===== sv/transcript_speech_metrics_unit_assert.svh =====
// Assertion macros for the block's top-level file.
`ifndef TRANSCRIPT_SPEECH_METRICS_UNIT_ASSERT_SVH
`define TRANSCRIPT_SPEECH_METRICS_UNIT_ASSERT_SVH
// Implication checked at every clock edge outside reset.
`define TSM_ASSERT_IMP(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error("lbl");
// Next-cycle implication.
`define TSM_ASSERT_NXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error("lbl");
`endif

// ===== sv/tsm_pkg.sv =====
package tsm_pkg;
  localparam int WindowLenDef = 11;
  localparam int CountBitsDef = 32;
  localparam logic [23:0] WpmScale = 24'd15360000;
  localparam int FillerNum = 8;

  // Events of one byte, lowest bit first: word, sentence, filler, last,
  // pending dot at the end, filler ending at the newest byte.
  typedef struct packed {
    logic fill_fin;
    logic dot_fin;
    logic last;
    logic fill_inc;
    logic sent_inc;
    logic word_inc;
  } tsm_evt_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return is_digit(c) || (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) ||
           (c == 8'h27);
  endfunction

  function automatic logic [7:0] filler_len(input int f);
    unique case (f)
      0, 1: return 8'd2;
      2: return 8'd4;
      3: return 8'd9;
      4, 5: return 8'd8;
      default: return 8'd7;
    endcase
  endfunction

  // Filler byte j (0 = first char) of filler f.
  function automatic logic [7:0] filler_chr(input int f, input int j);
    logic [8*9-1:0] s;
    unique case (f)
      0: s = {"um", 56'd0};
      1: s = {"uh", 56'd0};
      2: s = {"like", 40'd0};
      3: s = "basically";
      4: s = {"actually", 8'd0};
      5: s = {"you know", 8'd0};
      6: s = {"kind of", 16'd0};
      default: s = {"sort of", 16'd0};
    endcase
    return s[8*(8-j) +: 8];
  endfunction
endpackage

// ===== sv/tsm_front.sv =====
module tsm_front import tsm_pkg::*; #(
  parameter int WINDOW_LEN = WindowLenDef
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_fire,
  input  logic [7:0] text_byte,
  input  logic       byte_valid,
  input  logic       last_byte,
  output tsm_evt_t   evt
);
  logic [7:0] win_r [WINDOW_LEN];
  logic [7:0] win_nxt [WINDOW_LEN];
  logic [WINDOW_LEN-1:0] pres_r, pres_nxt;
  logic in_word_r, dot_pend_r, dot_dig_r;
  logic [7:0] lc;
  logic dot_sent;

  function automatic logic scan(input logic [7:0] w [WINDOW_LEN],
                                input logic [WINDOW_LEN-1:0] p, input int e);
    logic any;
    logic ok;
    int len;
    int left;
    any = 1'b0;
    for (int f = 0; f < FillerNum; f++) begin
      len = int'(filler_len(f));
      left = e + len;
      if (left < WINDOW_LEN) begin
        ok = 1'b1;
        for (int j = 0; j < 9; j++)
          if (j < len)
            if (!p[e+len-1-j] || w[e+len-1-j] != filler_chr(f, j)) ok = 1'b0;
        if (e > 0 && p[e-1] && is_word(w[e-1])) ok = 1'b0;
        if (p[left] && is_word(w[left])) ok = 1'b0;
        any = any | ok;
      end
    end
    return any;
  endfunction

  assign lc = (text_byte >= 8'h41 && text_byte <= 8'h5a) ? text_byte + 8'd32 : text_byte;

  always_comb begin
    win_nxt = win_r;
    pres_nxt = pres_r;
    if (byte_valid) begin
      for (int i = WINDOW_LEN - 1; i > 0; i--) begin
        win_nxt[i] = win_r[i-1];
        pres_nxt[i] = pres_r[i-1];
      end
      win_nxt[0] = lc;
      pres_nxt[0] = 1'b1;
    end
  end

  assign dot_sent = byte_valid && dot_pend_r &&
                    !(text_byte == 8'h2e || (dot_dig_r && is_digit(text_byte)));

  // Fillers are mutually exclusive at one end position, so one per step.
  // On the final transaction a dot still waiting and a filler ending at the
  // newest byte are counted as well.
  always_comb begin
    evt.word_inc = byte_valid && is_word(text_byte) && !in_word_r;
    evt.sent_inc = dot_sent || (byte_valid && (text_byte == 8'h21 || text_byte == 8'h3f));
    evt.fill_inc = byte_valid && scan(win_nxt, pres_nxt, 1);
    evt.last = last_byte;
    evt.dot_fin = last_byte && (byte_valid ? (text_byte == 8'h2e) : dot_pend_r);
    evt.fill_fin = last_byte && scan(win_nxt, pres_nxt, 0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (in_fire && last_byte)) begin
      pres_r <= '0;
      in_word_r <= 1'b0;
      dot_pend_r <= 1'b0;
      dot_dig_r <= 1'b0;
    end else if (in_fire && byte_valid) begin
      win_r <= win_nxt;
      pres_r <= pres_nxt;
      in_word_r <= is_word(text_byte);
      dot_pend_r <= (text_byte == 8'h2e);
      if (text_byte == 8'h2e) dot_dig_r <= pres_r[0] && is_digit(win_r[0]);
    end
  end
endmodule

// ===== sv/tsm_back.sv =====
module tsm_back import tsm_pkg::*; #(
  parameter int COUNT_BITS = CountBitsDef
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  output logic           q_ready,
  input  logic [5:0]     q_flags,
  input  logic [31:0]    q_ms,
  output logic           res_valid,
  input  logic           res_ready,
  output logic [159:0]   res_data
);
  // Wide enough for words * 60000 * 256 at any counter width.
  localparam int DivBits = COUNT_BITS + 32;
  localparam logic [6:0] CntLast = 7'(DivBits - 1);
  typedef enum logic [3:0] {
    S_RUN = 4'b0001, S_DIV1 = 4'b0010, S_DIV2 = 4'b0100, S_OUT = 4'b1000
  } st_t;
  localparam logic [COUNT_BITS-1:0] CMax = '1;
  st_t st_r;
  logic [COUNT_BITS-1:0] w_r, s_r, f_r;
  logic [31:0] ms_r;
  logic [6:0] cnt_r;
  logic [DivBits-1:0] num_r, rem_r, quo_r;
  logic [DivBits:0] den_r;
  logic [31:0] wpm_r, avg_r;
  logic [DivBits:0] trial;
  logic [COUNT_BITS-1:0] w1, s1, s2, f1, f2;

  function automatic logic [COUNT_BITS-1:0] sinc(input logic [COUNT_BITS-1:0] v,
                                                 input logic e);
    return (e && v != CMax) ? v + COUNT_BITS'(1) : v;
  endfunction
  function automatic logic [31:0] clip(input logic [DivBits-1:0] v);
    return (|v[DivBits-1:32]) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  // flags: word, sent, fill, last, dot_fin, fill_fin
  assign w1 = sinc(w_r, q_flags[0]);
  assign s1 = sinc(s_r, q_flags[1]);
  assign s2 = sinc(s1, q_flags[3] & q_flags[4]);
  assign f1 = sinc(f_r, q_flags[2]);
  assign f2 = sinc(f1, q_flags[3] & q_flags[5]);
  assign q_ready = (st_r == S_RUN);
  assign trial = {rem_r, num_r[DivBits-1]} - den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_RUN;
      w_r <= '0; s_r <= '0; f_r <= '0;
    end else begin
      unique case (st_r)
        S_RUN: if (q_valid) begin
          w_r <= w1; s_r <= s2; f_r <= f2;
          if (q_flags[3]) begin
            ms_r <= q_ms;
            // words*256 / max(sentences,1)
            num_r <= DivBits'({w1, 8'd0});
            den_r <= (s2 == '0) ? (DivBits+1)'(1) : (DivBits+1)'(s2);
            rem_r <= '0; quo_r <= '0; cnt_r <= '0;
            st_r <= S_DIV1;
          end
        end
        S_DIV1, S_DIV2: begin
          if (cnt_r != CntLast) begin
            if (!trial[DivBits]) begin
              rem_r <= trial[DivBits-1:0];
              quo_r <= {quo_r[DivBits-2:0], 1'b1};
            end else begin
              rem_r <= {rem_r[DivBits-2:0], num_r[DivBits-1]};
              quo_r <= {quo_r[DivBits-2:0], 1'b0};
            end
            num_r <= num_r << 1;
            cnt_r <= cnt_r + 7'd1;
          end else if (st_r == S_DIV1) begin
            avg_r <= clip(trial[DivBits] ? {quo_r[DivBits-2:0], 1'b0}
                                         : {quo_r[DivBits-2:0], 1'b1});
            num_r <= DivBits'(w_r) * DivBits'(WpmScale);
            den_r <= (DivBits+1)'(ms_r);
            rem_r <= '0; quo_r <= '0; cnt_r <= '0;
            if (ms_r == '0) begin
              wpm_r <= '0;
              st_r <= S_OUT;
            end else begin
              st_r <= S_DIV2;
            end
          end else begin
            wpm_r <= clip(trial[DivBits] ? {quo_r[DivBits-2:0], 1'b0}
                                         : {quo_r[DivBits-2:0], 1'b1});
            cnt_r <= '0;
            st_r <= S_OUT;
          end
        end
        S_OUT: if (res_ready) begin
          st_r <= S_RUN;
          w_r <= '0; s_r <= '0; f_r <= '0;
        end
        default: st_r <= S_RUN;
      endcase
    end
  end

  assign res_valid = (st_r == S_OUT);
  assign res_data = {avg_r, wpm_r, clip(DivBits'(f_r)), clip(DivBits'(s_r)),
                     clip(DivBits'(w_r))};
endmodule

// ===== sv/transcript_speech_metrics_unit.sv =====
// Transcript speech metrics.
// Input channel in_*: one transcript byte per transaction. in_tdata holds
// text_byte, in_tuser holds byte_valid, in_tlast marks the last byte and
// in_tdata[39:8] carries duration_ms with it.
// Output channel out_*: one result transaction per transcript, carrying the
// word, sentence and filler counts, words per minute and average sentence
// length (both Q.8), each 32 bits, first field in the lowest bits.
// Throughput: one byte per cycle while scanning; the front end classifies
// each byte in the cycle it is taken and a two-entry queue feeds the counters.
// After the last byte one restoring divider runs twice, COUNT_BITS+32 steps
// each (64 by default), before out_tvalid rises; with a zero duration the
// second run is skipped, so out_tvalid rises after the first run alone.
// Meanwhile the queue takes up to two bytes of the next transcript, then
// in_tready stays low until the result transaction is taken.
// A stalled out_tready holds the result and, once the queue fills, in_tready.
// Reset (rst_n low, synchronous) clears counters, window and queue.
`include "transcript_speech_metrics_unit_assert.svh"
module transcript_speech_metrics_unit import tsm_pkg::*; #(
  parameter int WINDOW_LEN = WindowLenDef,
  parameter int COUNT_BITS = CountBitsDef
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [39:0]  in_tdata,   // text_byte[7:0], duration_ms[39:8]
  input  logic         in_tuser,   // byte_valid
  input  logic         in_tlast,   // last_byte
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [159:0] out_tdata  // word, sentence, filler, wpm_q8, avg_q8
);
  logic in_fire, q_ready, q_valid;
  tsm_evt_t evt;
  logic [5:0] flags;
  logic [37:0] q_r [2];
  logic [1:0] q_cnt_r;

  assign in_tready = (q_cnt_r != 2'd2);
  assign in_fire = in_tvalid && in_tready;

  tsm_front #(.WINDOW_LEN(WINDOW_LEN)) u_front (
    .clk, .rst_n, .in_fire, .text_byte(in_tdata[7:0]),
    .byte_valid(in_tuser), .last_byte(in_tlast), .evt);

  assign flags = evt;

  // Two-entry queue between front and back.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_cnt_r <= '0;
    end else begin
      if (in_fire && !(q_valid && q_ready)) begin
        q_r[q_cnt_r[0]] <= {in_tdata[39:8], flags};
        q_cnt_r <= q_cnt_r + 2'd1;
      end else if (!in_fire && q_valid && q_ready) begin
        q_r[0] <= q_r[1];
        q_cnt_r <= q_cnt_r - 2'd1;
      end else if (in_fire) begin
        if (q_cnt_r == 2'd1) q_r[0] <= {in_tdata[39:8], flags};
        else begin
          q_r[0] <= q_r[1];
          q_r[1] <= {in_tdata[39:8], flags};
        end
      end
    end
  end
  assign q_valid = (q_cnt_r != 2'd0);

  tsm_back #(.COUNT_BITS(COUNT_BITS)) u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_flags(q_r[0][5:0]), .q_ms(q_r[0][37:6]),
    .res_valid(out_tvalid), .res_ready(out_tready), .res_data(out_tdata));

  `TSM_ASSERT_IMP(a_qbound, 1'b1, q_cnt_r <= 2'd2)
  `TSM_ASSERT_NXT(a_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
endmodule
